>>> hw/rtl/mbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_pkg
// Screen geometry, derived widths, register and command codes and the
// lane/plan types shared by the 1bpp bitmap blitter.
// ----------------------------------------------------------------------------
package mbb_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 800;
  localparam int SCREEN_HEIGHT = 480;
  localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8;
  localparam int FRAME_BYTES   = ROW_BYTES * SCREEN_HEIGHT;
  localparam int FB_AW         = $clog2(FRAME_BYTES);

  // Pixels carried by one source byte, one lane each
  localparam int LANES = 8;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_DEST_X       = 3'd0,
    REG_DEST_Y       = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_TRANSPARENT  = 3'd4
  } reg_index_t;

  localparam int REG_COUNT = 5;

  // Input command codes
  typedef enum logic {
    CMD_IMAGE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  // What one lane found for its pixel
  typedef struct packed {
    logic       hit;     // pixel is drawn
    logic       hi;      // pixel falls in the second destination byte
    logic [2:0] bitpos;  // pixel offset inside its destination byte, 0 = MSB
    logic       value;   // pixel value to store
  } lane_t;

  // Merged update for the two destination bytes
  typedef struct packed {
    logic [7:0] mask0;
    logic [7:0] val0;
    logic [7:0] mask1;
    logic [7:0] val1;
  } plan_t;

endpackage

>>> hw/rtl/mbb_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_lane
// One pixel of a source byte: clip against image width and screen edges,
// apply transparency and place the pixel in one of two destination bytes.
// ----------------------------------------------------------------------------
module mbb_lane (
  input  logic [2:0]    lane_idx,
  input  logic [9:0]    dest_x,
  input  logic [9:0]    image_width,
  input  logic [6:0]    byte_col,
  input  logic          pixel,
  input  logic          transparent,
  input  logic          row_on,
  output mbb_pkg::lane_t res
);

  logic [9:0]  col;
  logic [10:0] sx;
  logic [3:0]  pos;
  logic        in_screen;

  // Image column and screen column of this pixel
  assign col       = {byte_col, lane_idx};
  assign sx        = {1'b0, dest_x} + {1'b0, col};
  assign in_screen = 32'(sx) < 32'(mbb_pkg::SCREEN_WIDTH);

  // Offset from the first destination byte
  assign pos = {1'b0, dest_x[2:0]} + {1'b0, lane_idx};

  assign res.hit    = row_on && (col < image_width) && in_screen &&
                      !(transparent && pixel);
  assign res.hi     = pos[3];
  assign res.bitpos = pos[2:0];
  assign res.value  = pixel;

endmodule

>>> hw/rtl/mbb_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_merge
// Combine the lane results into write masks and values for the two
// destination bytes that a source byte can straddle.
// ----------------------------------------------------------------------------
module mbb_merge (
  input  mbb_pkg::lane_t [mbb_pkg::LANES-1:0] lanes,
  output mbb_pkg::plan_t                      plan
);

  // OR each drawn pixel into its byte mask
  always_comb begin
    logic [2:0] bit_idx;
    plan = '0;
    bit_idx = '0;
    for (int i = 0; i < mbb_pkg::LANES; i++) begin
      bit_idx = 3'd7 - lanes[i].bitpos;
      if (lanes[i].hit) begin
        if (lanes[i].hi) begin
          plan.mask1[bit_idx] = 1'b1;
          plan.val1[bit_idx]  = lanes[i].value;
        end else begin
          plan.mask0[bit_idx] = 1'b1;
          plan.val0[bit_idx]  = lanes[i].value;
        end
      end
    end
  end

endmodule

>>> hw/rtl/mbb_frame_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_frame_store
// Framebuffer memory, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module mbb_frame_store (
  input  logic                     clk,
  input  logic                     we,
  input  logic [mbb_pkg::FB_AW-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [mbb_pkg::FB_AW-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [mbb_pkg::FRAME_BYTES];

  // Write and read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/mono_bitmap_blit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_bitmap_blit_unit
// 1bpp framebuffer with a clipping blitter: eight pixel lanes place each
// source byte, then two read-modify-writes update the frame memory.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | transfer when
//  ---------+-------------------------------------------+-------------------
//  in       | in_valid in_ready cmd source_byte         | in_valid & in_ready
//           | read_address                              |
//  out      | out_valid out_ready read_data image_done  | out_valid & out_ready
//  cfg      | cfg_we cfg_index cfg_data                 | cfg_we
//
//  An image byte passes through accept, lane plan + first read, first
//  write + second read and second write; a read is issued at accept and
//  captured in ST_READ. The single write port of the frame memory sets these steps.
//  After reset a clearing pass writes white to all FRAME_BYTES (48000)
//  bytes, one per cycle, before the first item is accepted.
//  A result waits in the output register; the next item is accepted once the
//  sequencer is idle and that register is free or being drained.
// ----------------------------------------------------------------------------
module mono_bitmap_blit_unit (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  source_byte,
  input  logic [15:0] read_address,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        image_done,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int AW = mbb_pkg::FB_AW;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_PLAN  = 6'b000100,
    ST_MOD0  = 6'b001000,
    ST_MOD1  = 6'b010000,
    ST_READ  = 6'b100000
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic [9:0] dest_x;
  logic [8:0] dest_y;
  logic [9:0] image_width;
  logic [9:0] image_height;
  logic       transparent_mode;
  logic       cfg_hit;

  // Image counters
  logic [9:0] source_row;
  logic [6:0] source_byte_column;

  // Per-item registers
  logic [7:0]       src_byte;
  mbb_pkg::plan_t   plan_q;
  logic [AW-1:0]    addr0;
  logic             done_flag;
  logic             rd_zero;
  logic [AW-1:0]    clr_addr;

  // Frame memory ports
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [7:0]       mem_rdata;

  logic             in_xfer;
  logic             rd_in_range;
  logic [31:0]      rd_addr_wide;
  logic             out_load;

  // Plan datapath
  logic             img_ok;
  logic [10:0]      sy;
  logic             row_on;
  logic [7:0]       base_col;
  logic [31:0]      addr_wide;
  logic [AW-1:0]    addr0_c;
  logic [AW-1:0]    addr1;
  logic [10:0]      width_up;
  logic [7:0]       stride;
  logic [7:0]       col_p1;
  logic [10:0]      row_p1;
  logic             row_wrap;
  mbb_pkg::lane_t [mbb_pkg::LANES-1:0] lanes;
  mbb_pkg::plan_t   plan_c;

  assign in_ready     = (state == ST_IDLE) && (!out_valid || out_ready);
  assign in_xfer      = in_valid && in_ready;
  assign rd_addr_wide = 32'(read_address);
  assign rd_in_range  = rd_addr_wide < 32'(mbb_pkg::FRAME_BYTES);

  // Decode configuration index
  always_comb begin
    unique case (cfg_index)
      mbb_pkg::REG_DEST_X, mbb_pkg::REG_DEST_Y, mbb_pkg::REG_IMAGE_WIDTH,
      mbb_pkg::REG_IMAGE_HEIGHT, mbb_pkg::REG_TRANSPARENT: cfg_hit = 1'b1;
      default:                                             cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x           <= '0;
      dest_y           <= '0;
      image_width      <= '0;
      image_height     <= '0;
      transparent_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbb_pkg::REG_DEST_X:       dest_x           <= cfg_data;
        mbb_pkg::REG_DEST_Y:       dest_y           <= cfg_data[8:0];
        mbb_pkg::REG_IMAGE_WIDTH:  image_width      <= cfg_data;
        mbb_pkg::REG_IMAGE_HEIGHT: image_height     <= cfg_data;
        mbb_pkg::REG_TRANSPARENT:  transparent_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Lane inputs shared by all eight pixels
  assign img_ok   = (image_width != '0) && (image_height != '0);
  assign sy       = {2'b00, dest_y} + {1'b0, source_row};
  assign row_on   = img_ok && (32'(sy) < 32'(mbb_pkg::SCREEN_HEIGHT));
  assign base_col = {1'b0, dest_x[9:3]} + {1'b0, source_byte_column};
  assign addr_wide = 32'(sy) * 32'(mbb_pkg::ROW_BYTES) + 32'(base_col);
  assign addr0_c  = addr_wide[AW-1:0];
  assign addr1    = addr0 + AW'(1);

  genvar g;
  generate
    for (g = 0; g < mbb_pkg::LANES; g++) begin : g_lane
      mbb_lane u_lane (
        .lane_idx    (3'(g)),
        .dest_x      (dest_x),
        .image_width (image_width),
        .byte_col    (source_byte_column),
        .pixel       (src_byte[7-g]),
        .transparent (transparent_mode),
        .row_on      (row_on),
        .res         (lanes[g])
      );
    end
  endgenerate

  mbb_merge u_merge (
    .lanes (lanes),
    .plan  (plan_c)
  );

  // Counter advance
  assign width_up = {1'b0, image_width} + 11'd7;
  assign stride   = width_up[10:3];
  assign col_p1   = {1'b0, source_byte_column} + 8'd1;
  assign row_p1   = {1'b0, source_row} + 11'd1;
  assign row_wrap = row_p1 >= {1'b0, image_height};

  always_ff @(posedge clk) begin
    if (rst) begin
      source_row         <= '0;
      source_byte_column <= '0;
    end else if (cfg_we && cfg_hit) begin
      source_row         <= '0;
      source_byte_column <= '0;
    end else if (state == ST_PLAN && img_ok) begin
      if (col_p1 >= stride) begin
        source_byte_column <= '0;
        source_row         <= row_wrap ? '0 : row_p1[9:0];
      end else begin
        source_byte_column <= col_p1[6:0];
      end
    end
  end

  // Latch item and plan
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      src_byte <= source_byte;
      rd_zero  <= !rd_in_range;
    end
    if (state == ST_PLAN) begin
      plan_q    <= plan_c;
      addr0     <= addr0_c;
      done_flag <= img_ok && (col_p1 >= stride) && row_wrap;
    end
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == AW'(mbb_pkg::FRAME_BYTES - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_xfer) state_next = (cmd == mbb_pkg::CMD_READ) ? ST_READ : ST_PLAN;
      end
      ST_PLAN: state_next = ST_MOD0;
      ST_MOD0: state_next = ST_MOD1;
      ST_MOD1: state_next = ST_IDLE;
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Frame memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr0;
    mem_wdata = (mem_rdata & ~plan_q.mask0) | (plan_q.val0 & plan_q.mask0);
    mem_re    = 1'b0;
    mem_raddr = addr0_c;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = 8'hFF;
      end
      ST_IDLE: begin
        mem_re    = in_xfer && (cmd == mbb_pkg::CMD_READ) && rd_in_range;
        mem_raddr = rd_addr_wide[AW-1:0];
      end
      ST_PLAN: begin
        mem_re    = plan_c.mask0 != '0;
        mem_raddr = addr0_c;
      end
      ST_MOD0: begin
        mem_we    = plan_q.mask0 != '0;
        mem_re    = plan_q.mask1 != '0;
        mem_raddr = addr1;
      end
      ST_MOD1: begin
        mem_we    = plan_q.mask1 != '0;
        mem_waddr = addr1;
        mem_wdata = (mem_rdata & ~plan_q.mask1) | (plan_q.val1 & plan_q.mask1);
      end
      default: ;
    endcase
  end

  mbb_frame_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: load a finished result, drop it on transfer
  assign out_load = (state == ST_MOD1) || (state == ST_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MOD1) begin
      read_data  <= '0;
      image_done <= done_flag;
    end else if (state == ST_READ) begin
      read_data  <= rd_zero ? 8'h00 : mem_rdata;
      image_done <= 1'b0;
    end
  end

endmodule
